// ----- rtl/ptc_pkg.sv -----
// Shared types and register codes for the periodic timer counter.
`timescale 1ns / 1ps

package ptc_pkg;

  localparam int OpW   = 2;
  localparam int AddrW = 4;
  localparam int ByteW = 8;
  localparam int CntW  = 16;

  localparam logic [OpW-1:0] OP_TICK  = 2'd0;
  localparam logic [OpW-1:0] OP_READ  = 2'd1;
  localparam logic [OpW-1:0] OP_WRITE = 2'd2;

  localparam logic [AddrW-1:0] ADDR_CTRLA    = 4'd0;
  localparam logic [AddrW-1:0] ADDR_CTRLB    = 4'd1;
  localparam logic [AddrW-1:0] ADDR_INTCTRL  = 4'd5;
  localparam logic [AddrW-1:0] ADDR_INTFLAGS = 4'd6;
  localparam logic [AddrW-1:0] ADDR_TEMP     = 4'd9;
  localparam logic [AddrW-1:0] ADDR_CNTL     = 4'd10;
  localparam logic [AddrW-1:0] ADDR_CNTH     = 4'd11;
  localparam logic [AddrW-1:0] ADDR_CCMPL    = 4'd12;
  localparam logic [AddrW-1:0] ADDR_CCMPH    = 4'd13;

  localparam logic [CntW-1:0] CNT_MAX = 16'hFFFF;

  typedef struct packed {
    logic [OpW-1:0]   operation;
    logic [AddrW-1:0] address;
    logic [ByteW-1:0] write_data;
    logic             tca_pulse;
  } item_t;

  typedef struct packed {
    logic [ByteW-1:0] read_data;
    logic             irq;
  } result_t;

endpackage

// ----- rtl/ptc_core.sv -----
// Timer register file, clock source selection and count/compare logic.
`timescale 1ns / 1ps

module ptc_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            fire,
  input  ptc_pkg::item_t  item,
  output ptc_pkg::result_t result
);

  localparam logic [1:0] SRC_OFF   = 2'd0;
  localparam logic [1:0] SRC_DIV1  = 2'd1;
  localparam logic [1:0] SRC_DIV2  = 2'd2;
  localparam logic [1:0] SRC_PULSE = 2'd3;

  function automatic logic [1:0] source_of(input logic [2:0] sel);
    logic [1:0] src;
    src = SRC_OFF;
    if (sel[0]) begin
      case (sel[2:1])
        2'd0:    src = SRC_DIV1;
        2'd1:    src = SRC_DIV2;
        2'd2:    src = SRC_PULSE;
        default: src = SRC_OFF;
      endcase
    end
    return src;
  endfunction

  logic [2:0]                 clock_select, clock_select_next;
  logic [2:0]                 count_mode, count_mode_next;
  logic                       int_enable, int_enable_next;
  logic                       int_flag, int_flag_next;
  logic [ptc_pkg::ByteW-1:0]  temp_byte, temp_byte_next;
  logic [ptc_pkg::CntW-1:0]   count, count_next;
  logic [ptc_pkg::CntW-1:0]   compare, compare_next;
  logic                       phase, phase_next;

  logic [1:0]                 src;
  logic                       count_en;
  logic [ptc_pkg::CntW-1:0]   cnt_plus;
  logic                       hit;
  logic [ptc_pkg::CntW-1:0]   cnt_cleared;
  logic [ptc_pkg::ByteW-1:0]  rd;

  assign src         = source_of(clock_select);
  assign cnt_plus    = count + ptc_pkg::CntW'(1);
  assign hit         = (cnt_plus == compare);
  assign cnt_cleared = (hit || cnt_plus == ptc_pkg::CNT_MAX) ? '0 : cnt_plus;
  assign count_en    = (src == SRC_DIV1) || (src == SRC_DIV2 && phase) ||
                       (src == SRC_PULSE && item.tca_pulse);

  always_comb begin
    clock_select_next = clock_select;
    count_mode_next   = count_mode;
    int_enable_next   = int_enable;
    int_flag_next     = int_flag;
    temp_byte_next    = temp_byte;
    count_next        = count;
    compare_next      = compare;
    phase_next        = phase;
    rd                = '0;
    case (item.operation)
      ptc_pkg::OP_TICK: begin
        if (src == SRC_DIV2) begin
          phase_next = ~phase;
        end
        if (count_en) begin
          count_next = cnt_cleared;
          if (hit) begin
            int_flag_next = 1'b1;
          end
        end
      end
      ptc_pkg::OP_READ: begin
        case (item.address)
          ptc_pkg::ADDR_CTRLA:    rd = {5'd0, clock_select};
          ptc_pkg::ADDR_CTRLB:    rd = {5'd0, count_mode};
          ptc_pkg::ADDR_INTCTRL:  rd = {7'd0, int_enable};
          ptc_pkg::ADDR_INTFLAGS: rd = {7'd0, int_flag};
          ptc_pkg::ADDR_TEMP:     rd = temp_byte;
          ptc_pkg::ADDR_CNTL: begin
            rd             = count[7:0];
            temp_byte_next = count[15:8];
          end
          ptc_pkg::ADDR_CCMPL: begin
            rd             = compare[7:0];
            temp_byte_next = compare[15:8];
          end
          ptc_pkg::ADDR_CNTH:     rd = temp_byte;
          ptc_pkg::ADDR_CCMPH:    rd = temp_byte;
          default:                rd = '0;
        endcase
      end
      ptc_pkg::OP_WRITE: begin
        case (item.address)
          ptc_pkg::ADDR_CTRLA: begin
            if (source_of(item.write_data[2:0]) != src) begin
              phase_next = 1'b0;
            end
            clock_select_next = item.write_data[2:0];
          end
          ptc_pkg::ADDR_CTRLB:    count_mode_next = item.write_data[2:0];
          ptc_pkg::ADDR_INTCTRL:  int_enable_next = item.write_data[0];
          ptc_pkg::ADDR_INTFLAGS: begin
            if (item.write_data[0]) begin
              int_flag_next = 1'b0;
            end
          end
          ptc_pkg::ADDR_TEMP:     temp_byte_next = item.write_data;
          ptc_pkg::ADDR_CNTL:     temp_byte_next = item.write_data;
          ptc_pkg::ADDR_CCMPL:    temp_byte_next = item.write_data;
          ptc_pkg::ADDR_CNTH:     count_next = {item.write_data, temp_byte};
          ptc_pkg::ADDR_CCMPH:    compare_next = {item.write_data, temp_byte};
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign result.read_data = rd;
  assign result.irq       = int_flag_next & int_enable_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_select <= '0;
      count_mode   <= '0;
      int_enable   <= 1'b0;
      int_flag     <= 1'b0;
      temp_byte    <= '0;
      count        <= '0;
      compare      <= '0;
      phase        <= 1'b0;
    end else if (fire) begin
      clock_select <= clock_select_next;
      count_mode   <= count_mode_next;
      int_enable   <= int_enable_next;
      int_flag     <= int_flag_next;
      temp_byte    <= temp_byte_next;
      count        <= count_next;
      compare      <= compare_next;
      phase        <= phase_next;
    end
  end

endmodule

// ----- rtl/periodic_timer_counter_16bit.sv -----
// Top level of the 16-bit periodic timer counter with stream request ports.
//
//  channel | dir | handshake          | payload
//  s_*     | in  | s_tvalid/s_tready  | s_tuser: operation; s_tdata: address, write_data, tca_pulse
//  m_*     | out | m_tvalid/m_tready  | m_tdata: read_data, irq
//
// One request per cycle sustained while m_tready is held high; each result is
// registered after its request is accepted (input register, then result register).
// Synchronous active-high reset clears all timer registers and both valid flags.
// A stalled result holds the result register; the input register still takes
// one more request, after which s_tready drops until the result drains.
`timescale 1ns / 1ps

module periodic_timer_counter_16bit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [1:0]  s_tuser,   // [1:0] operation
  input  logic [15:0] s_tdata,   // [3:0] address, [11:4] write_data, [12] tca_pulse
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // [7:0] read_data, [8] irq
);

  logic             in_valid;
  ptc_pkg::item_t   in_item;
  logic             s_fire;
  logic             advance;
  ptc_pkg::result_t core_result;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;
  assign s_fire   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_fire) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      in_item.operation  <= s_tuser;
      in_item.address    <= s_tdata[3:0];
      in_item.write_data <= s_tdata[11:4];
      in_item.tca_pulse  <= s_tdata[12];
    end
  end

  ptc_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .item   (in_item),
    .result (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {7'd0, core_result.irq, core_result.read_data};
    end
  end

`ifndef SYNTHESIS
  a_advance_shows: assert property (@(posedge clk) disable iff (rst)
    advance |=> m_tvalid)
    else $error("result register not loaded after advance");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !in_valid |-> s_tready)
    else $error("input register empty but not ready");

  a_input_holds: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !advance) |=> (in_valid && $stable(in_item)))
    else $error("pending request lost or changed while stalled");
`endif

endmodule
